@@ rtl/vht_pkg.sv @@
`timescale 1ns / 1ps
package vht_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = 64;

	typedef enum logic [1:0] {
		CMD_VISIT  = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] key_hash;
		logic [31:0] time_now;
	} item_t;

	typedef struct packed {
		logic       found;
		logic       evicted;
		logic [9:0] entry_count;
	} result_t;

	// saturate the stored count into the 10-bit result field
	function automatic logic [9:0] count_field(input logic [CW-1:0] cnt);
		logic [31:0] c32;
		c32 = 32'(cnt);
		count_field = (c32 > 32'd1023) ? 10'd1023 : c32[9:0];
	endfunction

endpackage

@@ rtl/vht_ram.sv @@
`timescale 1ns / 1ps
module vht_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/visited_hash_table_lru_top.sv @@
`timescale 1ns / 1ps
// Sorted set of up to TABLE_DEPTH 32-bit keys, each with a last-visited time, held in one
// RAM of {key, time} words. Take a command when busy is low by raising start; the result
// appears for one cycle with done and cannot be held off. Clear and unknown commands
// answer in the cycle after the start beat. Lookup walks the table. A visit walks the
// table, and on a miss shifts entries through the RAM: when the table is full it first
// shifts entries down to close the oldest entry, which is evicted, then shifts entries up
// to open the slot at the sorted position. The single RAM port pair moves one entry per
// cycle in each walk and shift.
module visited_hash_table_lru_top
	import vht_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);
	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_REM, ST_INS} state_t;

	state_t          state_q;
	logic [1:0]      cmd_q;
	logic [31:0]     key_q, now_q, oldt_q;
	logic [CW-1:0]   cnt_q, a_q, old_q, less_q, pos_q, idx_s1;
	logic            v_s1, ev_q, done_q;
	result_t         res_q;

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [EW-1:0]   wdata, rdata;
	logic [31:0]     rkey, rtime;
	logic            hit_now, full;

	assign rkey    = rdata[63:32];
	assign rtime   = rdata[31:0];
	assign hit_now = v_s1 && (rkey == key_q);
	assign full    = (cnt_q == CW'(TABLE_DEPTH));
	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign result  = res_q;

	vht_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// drive RAM ports per phase
	always_comb begin
		we    = 1'b0;
		waddr = idx_s1[AW-1:0];
		wdata = {key_q, now_q};
		raddr = a_q[AW-1:0];
		unique case (state_q)
			ST_SCAN: we = hit_now && (cmd_q == CMD_VISIT);
			ST_REM: begin
				we    = v_s1;
				waddr = AW'(idx_s1 - CW'(1));
				wdata = rdata;
			end
			ST_INS: begin
				raddr = AW'(a_q - CW'(1));
				if (v_s1) begin
					we    = 1'b1;
					waddr = AW'(idx_s1 + CW'(1));
					wdata = rdata;
				end else if (a_q == pos_q) begin
					we    = 1'b1;
					waddr = pos_q[AW-1:0];
				end
			end
			default: ;
		endcase
	end

	// sequence commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q  <= item.cmd;
						key_q  <= item.key_hash;
						now_q  <= item.time_now;
						a_q    <= '0;
						v_s1   <= 1'b0;
						old_q  <= '0;
						oldt_q <= item.time_now;
						less_q <= '0;
						if (item.cmd == CMD_VISIT || item.cmd == CMD_LOOKUP) begin
							state_q <= ST_SCAN;
						end else if (item.cmd == CMD_CLEAR) begin
							cnt_q  <= '0;
							done_q <= 1'b1;
							res_q  <= '{found: 1'b0, evicted: 1'b0, entry_count: 10'd0};
						end else begin
							done_q <= 1'b1;
							res_q  <= '{found: 1'b0, evicted: 1'b0,
								entry_count: count_field(cnt_q)};
						end
					end
				end
				ST_SCAN: begin
					if (hit_now) begin
						done_q  <= 1'b1;
						res_q   <= '{found: 1'b1, evicted: 1'b0,
							entry_count: count_field(cnt_q)};
						state_q <= ST_IDLE;
					end else begin
						// track oldest entry and sorted position
						if (v_s1) begin
							if (rtime < oldt_q) begin
								old_q  <= idx_s1;
								oldt_q <= rtime;
							end
							if (rkey < key_q) less_q <= less_q + CW'(1);
						end
						if (a_q < cnt_q) begin
							v_s1   <= 1'b1;
							idx_s1 <= a_q;
							a_q    <= a_q + CW'(1);
						end else begin
							v_s1 <= 1'b0;
						end
						if (a_q == cnt_q && !v_s1) begin
							if (cmd_q == CMD_LOOKUP) begin
								done_q  <= 1'b1;
								res_q   <= '{found: 1'b0, evicted: 1'b0,
									entry_count: count_field(cnt_q)};
								state_q <= ST_IDLE;
							end else if (full) begin
								ev_q    <= 1'b1;
								a_q     <= old_q + CW'(1);
								pos_q   <= (old_q < less_q) ? less_q - CW'(1) : less_q;
								state_q <= ST_REM;
							end else begin
								ev_q    <= 1'b0;
								a_q     <= cnt_q;
								pos_q   <= less_q;
								state_q <= ST_INS;
							end
						end
					end
				end
				ST_REM: begin
					// shift entries down over the evicted one
					if (a_q < cnt_q) begin
						v_s1   <= 1'b1;
						idx_s1 <= a_q;
						a_q    <= a_q + CW'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (a_q == cnt_q && !v_s1) begin
						cnt_q   <= cnt_q - CW'(1);
						a_q     <= cnt_q - CW'(1);
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					// shift entries up to open the slot
					if (a_q > pos_q) begin
						v_s1   <= 1'b1;
						idx_s1 <= a_q - CW'(1);
						a_q    <= a_q - CW'(1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (a_q == pos_q && !v_s1) begin
						cnt_q   <= cnt_q + CW'(1);
						done_q  <= 1'b1;
						res_q   <= '{found: 1'b0, evicted: ev_q,
							entry_count: count_field(cnt_q + CW'(1))};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE) else $error("result while busy");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH)) else $error("count beyond depth");
	a_ev_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.evicted |-> !res_q.found) else $error("evict on hit");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done_q) else $error("command dropped");
endmodule
